FILE: src/lesf_pkg.sv
// ----------------------------------------------------------------------------
// lesf_pkg
// shared constants and types for the largest empty square finder
// ----------------------------------------------------------------------------
package lesf_pkg;

    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 1024;

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int SIZE_W = 11;
    localparam int CHAR_W = 8;
    localparam int WID_W  = 11;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [SIZE_W-1:0] SIZE_MAX = {SIZE_W{1'b1}};

    // register indexes, taken from paddr[2]
    localparam logic REG_ROW_WIDTH  = 1'b0;
    localparam logic REG_EMPTY_CHAR = 1'b1;

    localparam logic [WID_W-1:0]  ROW_WIDTH_RST  = WID_W'(1);
    localparam logic [CHAR_W-1:0] EMPTY_CHAR_RST = CHAR_W'(46);

    // line store write request
    typedef struct packed {
        logic              en;
        logic [COL_W-1:0]  addr;
        logic [SIZE_W-1:0] data;
    } t_ls_wr;

    // line store read request
    typedef struct packed {
        logic             en;
        logic [COL_W-1:0] addr;
    } t_ls_rd;

endpackage

FILE: src/largest_empty_square_finder_core.sv
// ----------------------------------------------------------------------------
// largest_empty_square_finder_core
// streaming maximal-square search over a character map
// ----------------------------------------------------------------------------
// Cells arrive one per request in row-major order and the block takes a new
// cell every cycle unless stalled, so throughput is one cell per cycle. The
// one stall: when the last cell of a map sits in the compute stage while the
// output register still holds a result that has not been taken, the input is
// held off until i_out_ready rises, and ready follows it in the same cycle.
// The output register loads the result as the compute stage fires the map_end
// cell: the previous row's size is read from the line store at its accepting
// edge, and the min-plus-one compute, write-back and output register load
// happen as the stage fires. The line store needs no clearing pass after
// reset, as the first row of every map writes each entry before it is used.
// row_width (byte address 0) and empty_char (byte address 4) are to be written
// by the user over the APB port only while no map cell is in flight; the
// block does not enforce it. row_width of 0 acts as 1 and values above 1024
// act as 1024. A map with no free cell reports size 0 at row 0, column 0.
module largest_empty_square_finder_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // cell requests
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [lesf_pkg::CHAR_W-1:0]  i_cell_char,
    input  logic                         i_map_end,
    // result requests
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [lesf_pkg::SIZE_W-1:0]  o_best_size,
    output logic [lesf_pkg::ROW_W-1:0]   o_best_row,
    output logic [lesf_pkg::COL_W-1:0]   o_best_col,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lesf_pkg::ADDR_W-1:0]  paddr,
    input  logic [lesf_pkg::DATA_W-1:0]  pwdata,
    output logic [lesf_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import lesf_pkg::*;

    // configuration registers
    logic [WID_W-1:0]  r_row_width;
    logic [CHAR_W-1:0] r_empty_char;

    // raster position of the next cell
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;

    // compute stage
    logic              r_s1_valid;
    logic              r_s1_free;
    logic              r_s1_first;
    logic              r_s1_last;
    logic [COL_W-1:0]  r_s1_col;
    logic [ROW_W-1:0]  r_s1_row;

    // neighbor sizes and best so far
    logic [SIZE_W-1:0] r_left;
    logic [SIZE_W-1:0] r_diag;
    logic [SIZE_W-1:0] r_best_size;
    logic [ROW_W-1:0]  r_best_row;
    logic [COL_W-1:0]  r_best_col;

    // output register
    logic              r_out_valid;
    logic [SIZE_W-1:0] r_out_size;
    logic [ROW_W-1:0]  r_out_row;
    logic [COL_W-1:0]  r_out_col;

    logic              cfg_wr;
    logic              in_accept;
    logic              s1_fire;
    logic [WID_W-1:0]  eff_width;
    logic [WID_W-1:0]  col_plus;
    logic              row_wrap;
    logic              row_hold;
    logic [SIZE_W-1:0] up_size;
    logic [SIZE_W-1:0] min_ul;
    logic [SIZE_W-1:0] min_all;
    logic [SIZE_W-1:0] n_size;
    logic              n_better;
    t_ls_wr            ls_wr;
    t_ls_rd            ls_rd;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width  <= ROW_WIDTH_RST;
            r_empty_char <= EMPTY_CHAR_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_ROW_WIDTH:  r_row_width  <= pwdata[WID_W-1:0];
                REG_EMPTY_CHAR: r_empty_char <= pwdata[CHAR_W-1:0];
                default:        r_row_width  <= r_row_width;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_ROW_WIDTH:  prdata = DATA_W'(r_row_width);
            REG_EMPTY_CHAR: prdata = DATA_W'(r_empty_char);
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------
    // the compute stage stalls only when it holds the last cell of a map
    // and the previous result has not been taken
    assign s1_fire    = r_s1_valid && (!r_s1_last || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_fire;
    assign in_accept  = i_in_valid && o_in_ready;

    // ------------------------------------------------------------------
    // raster position
    // ------------------------------------------------------------------
    always_comb begin
        if (r_row_width == '0) begin
            eff_width = WID_W'(1);
        end else if (r_row_width > WID_W'(MAX_COLS)) begin
            eff_width = WID_W'(MAX_COLS);
        end else begin
            eff_width = r_row_width;
        end
    end

    assign col_plus = WID_W'(r_col) + WID_W'(1);
    assign row_wrap = col_plus >= eff_width;
    // row index saturates at the last row
    assign row_hold = (ROW_W + 1)'(r_row) + (ROW_W + 1)'(1) >= (ROW_W + 1)'(MAX_ROWS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_accept) begin
            if (i_map_end) begin
                r_col <= '0;
                r_row <= '0;
            end else if (row_wrap) begin
                r_col <= '0;
                if (!row_hold) begin
                    r_row <= r_row + ROW_W'(1);
                end
            end else begin
                r_col <= col_plus[COL_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage one: cell classified, previous-row size read in flight
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_free  <= (i_cell_char == r_empty_char);
            r_s1_first <= (r_row == '0) || (r_col == '0);
            r_s1_last  <= i_map_end;
            r_s1_col   <= r_col;
            r_s1_row   <= r_row;
        end
    end

    assign ls_rd.en   = in_accept;
    assign ls_rd.addr = r_col;

    lesf_line_store u_line_store (
        .i_clk     (i_clk),
        .i_wr      (ls_wr),
        .i_rd      (ls_rd),
        .o_rd_data (up_size)
    );

    // ------------------------------------------------------------------
    // compute: min of up, left, diagonal plus one, saturating
    // ------------------------------------------------------------------
    assign min_ul  = (up_size < r_left) ? up_size : r_left;
    assign min_all = (r_diag < min_ul) ? r_diag : min_ul;

    always_comb begin
        if (!r_s1_free) begin
            n_size = '0;
        end else if (r_s1_first) begin
            n_size = SIZE_W'(1);
        end else if (min_all == SIZE_MAX) begin
            n_size = SIZE_MAX;
        end else begin
            n_size = min_all + SIZE_W'(1);
        end
    end

    // strictly larger only, so the earliest square wins
    assign n_better = n_size > r_best_size;

    assign ls_wr.en   = s1_fire;
    assign ls_wr.addr = r_s1_col;
    assign ls_wr.data = n_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= '0;
            r_diag      <= '0;
            r_best_size <= '0;
            r_best_row  <= '0;
            r_best_col  <= '0;
        end else if (s1_fire) begin
            if (r_s1_last) begin
                // map done, start clean
                r_left      <= '0;
                r_diag      <= '0;
                r_best_size <= '0;
                r_best_row  <= '0;
                r_best_col  <= '0;
            end else begin
                r_left <= n_size;
                r_diag <= up_size;
                if (n_better) begin
                    r_best_size <= n_size;
                    r_best_row  <= r_s1_row;
                    r_best_col  <= r_s1_col;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1_last) begin
            if (n_better) begin
                r_out_size <= n_size;
                r_out_row  <= r_s1_row;
                r_out_col  <= r_s1_col;
            end else begin
                r_out_size <= r_best_size;
                r_out_row  <= r_best_row;
                r_out_col  <= r_best_col;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_best_size = r_out_size;
    assign o_best_row  = r_out_row;
    assign o_best_col  = r_out_col;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && r_s1_last |=> r_out_valid)
        else $error("last cell of a map did not produce a result");

    a_map_end_clears_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_map_end |=> (r_col == '0) && (r_row == '0))
        else $error("raster position not cleared after the last cell");

    a_last_clears_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && r_s1_last |=> (r_best_size == '0) && (r_left == '0) && (r_diag == '0))
        else $error("map state not cleared after a result");

    a_stall_holds_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_fire |=> r_s1_valid && $stable(r_s1_col) && $stable(up_size))
        else $error("stalled compute stage lost its cell");

endmodule

FILE: src/lesf_line_store.sv
// ----------------------------------------------------------------------------
// lesf_line_store
// square sizes of the previous row, registered read, write-through
// ----------------------------------------------------------------------------
module lesf_line_store (
    input  logic                   i_clk,
    input  lesf_pkg::t_ls_wr       i_wr,
    input  lesf_pkg::t_ls_rd       i_rd,
    output logic [lesf_pkg::SIZE_W-1:0] o_rd_data
);
    import lesf_pkg::*;

    logic [SIZE_W-1:0] r_mem [MAX_COLS];
    logic [SIZE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // same-entry write in the same cycle is forwarded to the read port
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            if (i_wr.en && (i_wr.addr == i_rd.addr)) begin
                r_rd_data <= i_wr.data;
            end else begin
                r_rd_data <= r_mem[i_rd.addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
